// File: rtl/rdwr_pkg.sv
// shared types and constants for the random draw without replacement core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rdwr_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 16;

	localparam int MODE_W      = 2;
	localparam int KEY_IO_W    = 16;
	localparam int RND_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int POOL_LEFT_W = 7;
	localparam int S_DATA_W    = 32;
	localparam int M_DATA_W    = 24;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_DRAW   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_RD_A,
		S_RD_B,
		S_WR_1,
		S_WR_2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd_b;
		logic wr_1;
		logic wr_2;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic draw_ok;
		logic append_ok;
		logic div_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/rdwr_ctrl.sv
// sequencing state machine for the draw pool
// depends on rdwr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdwr_ctrl
	import rdwr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.draw_ok)
					state_d = S_DIV;
				else if (stat.append_ok)
					state_d = S_RD_A;
				else
					state_d = S_DONE;
			end
			S_DIV: begin
				if (stat.div_done)
					state_d = S_RD_A;
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_WR_1;
			S_WR_1: state_d = S_WR_2;
			S_WR_2: state_d = S_DONE;
			S_DONE: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		s_tready     = 1'b0;
		cmd.commit   = out_load;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_RD_B:  cmd.rd_b = 1'b1;
			S_WR_1:  cmd.wr_1 = 1'b1;
			S_WR_2:  cmd.wr_2 = 1'b1;
			default: cmd.load = 1'b0;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/rdwr_datapath.sv
// key store, counts, serial remainder unit and result register
// depends on rdwr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rdwr_datapath
	import rdwr_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	input  wire logic [MODE_W-1:0]      mode,
	input  wire logic [KEY_IO_W-1:0]    new_key,
	input  wire logic [RND_W-1:0]       random_value,
	output dp_stat_t                    stat,
	output logic [KEY_IO_W-1:0]         drawn_key,
	output logic [STATUS_W-1:0]         status,
	output logic [POOL_LEFT_W-1:0]      pool_left
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int STEP_W = $clog2(RND_W);

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] rdata_q, hold_q, key_q;
	logic [RND_W-1:0]     rnd_q;
	logic [CNT_W-1:0]     rem_q;
	logic [STEP_W-1:0]    step_q;
	mode_t                mode_q;
	logic [CNT_W-1:0]     entry_count_q, pool_size_q;

	logic [CNT_W:0]       rem_trial;
	logic [CNT_W-1:0]     rem_next;
	logic [AW-1:0]        addr_a, addr_b, raddr, waddr;
	logic [KEY_WIDTH-1:0] wdata, key_in;
	logic                 we, full, empty, is_draw, is_append;
	logic [CNT_W-1:0]     pool_next, last;
	status_t              status_d;
	logic [31:0]          key_ext, drawn_ext, left_ext;

	assign key_ext = {16'b0, new_key};
	assign key_in  = key_ext[KEY_WIDTH-1:0];

	assign full      = (entry_count_q == CNT_W'(CAPACITY));
	assign empty     = (pool_size_q == '0);
	assign is_draw   = (mode_q == MODE_DRAW);
	assign is_append = (mode_q == MODE_APPEND);
	assign last      = pool_size_q - CNT_W'(1);

	assign stat.draw_ok   = is_draw && !empty;
	assign stat.append_ok = is_append && !full;
	assign stat.div_done  = (step_q == STEP_W'(RND_W - 1));

	// restoring remainder, one dividend bit a cycle
	assign rem_trial = {rem_q, rnd_q[RND_W-1]};
	assign rem_next  = (rem_trial >= {1'b0, pool_size_q}) ?
		CNT_W'(rem_trial - {1'b0, pool_size_q}) : rem_trial[CNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			key_q  <= key_in;
			rnd_q  <= random_value;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rnd_q  <= {rnd_q[RND_W-2:0], 1'b0};
			rem_q  <= rem_next;
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.rd_b)
			hold_q <= rdata_q;
	end

	// draw: a is the chosen slot, b the last undrawn one
	// append: a is the pool end, b the list end
	assign addr_a = is_draw ? rem_q[AW-1:0] : pool_size_q[AW-1:0];
	assign addr_b = is_draw ? last[AW-1:0] : entry_count_q[AW-1:0];
	assign raddr  = cmd.rd_b ? addr_b : addr_a;

	always_comb begin
		we    = cmd.wr_1 || cmd.wr_2;
		waddr = addr_a;
		wdata = key_q;
		if (cmd.wr_1) begin
			if (is_draw) begin
				waddr = addr_a;
				wdata = rdata_q;
			end else begin
				waddr = addr_b;
				wdata = hold_q;
			end
		end else if (cmd.wr_2) begin
			if (is_draw) begin
				waddr = addr_b;
				wdata = hold_q;
			end else begin
				waddr = addr_a;
				wdata = key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		pool_next = pool_size_q;
		status_d  = ST_DONE;
		case (mode_q)
			MODE_CLEAR:  pool_next = '0;
			MODE_APPEND: begin
				if (full)
					status_d = ST_FULL;
				else
					pool_next = pool_size_q + CNT_W'(1);
			end
			MODE_DRAW: begin
				if (empty)
					status_d = ST_EMPTY;
				else
					pool_next = last;
			end
			default: pool_next = pool_size_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			pool_size_q   <= '0;
		end else if (cmd.commit) begin
			pool_size_q <= pool_next;
			if (mode_q == MODE_CLEAR)
				entry_count_q <= '0;
			else if (is_append && !full)
				entry_count_q <= entry_count_q + CNT_W'(1);
		end
	end

	assign drawn_ext = 32'(hold_q);
	assign left_ext  = 32'(pool_next);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			drawn_key <= (is_draw && !empty) ? drawn_ext[KEY_IO_W-1:0] : '0;
			status    <= status_d;
			pool_left <= left_ext[POOL_LEFT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/random_draw_without_replacement_core.sv
// top level of the random draw without replacement core
// depends on rdwr_pkg, rdwr_ctrl and rdwr_datapath
//
// usage: one input word per item on the s_ side, one result word per item on
// the m_ side, both accepted when tvalid and tready are high together.
// s_tuser carries the mode (clear, append, draw), s_tdata the key and the
// random number. a draw takes the random number modulo the undrawn count,
// returns the key in that slot and swaps it behind the undrawn part.
// a draw runs decode, the serial remainder unit, then two store reads and
// two store writes for the swap; an append runs decode and the same reads
// and writes; clear, failed items and the unused mode go from decode to the
// result. items are handled one at a time, a new one only once the last has left.
// the result sits in an output register; while the receiver stalls the next
// item is still taken and runs, and it waits in its last state until the
// output register frees up.
// reset empties the pool at once; the key store keeps no reset value.
`timescale 1ns / 1ps
`default_nettype none

module random_draw_without_replacement_core
	import rdwr_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // new_key, random_value
	input  wire logic [MODE_W-1:0]   s_tuser,  // mode
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // drawn_key, pool_left, zero pad
	output logic [STATUS_W-1:0]      m_tuser   // status
);

	dp_cmd_t                cmd;
	dp_stat_t               stat;
	logic [KEY_IO_W-1:0]    drawn_key;
	logic [POOL_LEFT_W-1:0] pool_left;

	rdwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rdwr_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (s_tuser),
		.new_key      (s_tdata[KEY_IO_W-1:0]),
		.random_value (s_tdata[KEY_IO_W +: RND_W]),
		.stat         (stat),
		.drawn_key    (drawn_key),
		.status       (m_tuser),
		.pool_left    (pool_left)
	);

	assign m_tdata = {1'b0, pool_left, drawn_key};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while an item is in progress");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == 2'(ST_EMPTY)) |-> (m_tdata == '0))
		else $error("empty draw must return zero key and empty pool");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == 2'(ST_FULL)) |-> (m_tdata[KEY_IO_W-1:0] == '0))
		else $error("full append must return zero key");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

endmodule

`default_nettype wire
